>>> rtl/dnsqn_pkg.sv
// Package: shared widths, constants and result/error codes for the DNS question name parser.
package dnsqn_pkg;

  localparam int unsigned NAME_BYTES = 256;
  localparam int unsigned TLEN_W     = $clog2(NAME_BYTES);

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned QTYPE_W = 16;
  localparam int unsigned NLEN_W  = 8;
  localparam int unsigned ERR_W   = 2;

  localparam logic [3:0]        HEADER_BYTES = 4'd12;
  localparam logic [DATA_W-1:0] MAX_LABEL    = 8'd63;
  localparam logic [1:0]        TAIL_LAST    = 2'd3;
  localparam logic [DATA_W-1:0] DOT_CHAR     = 8'h2E;

  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  localparam logic [ERR_W-1:0] ERR_LABEL = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NAME  = 2'd2;

endpackage

>>> rtl/dns_question_name_parser.sv
// DNS question name parser: header skip, label walk, dotted text out, type/class tail.
//
// Takes one payload byte per transfer and sustains one byte per cycle; each byte's result
// (a name character, done with type and name length, or an error) appears in the output
// register on the cycle after its transfer. The per-byte state update and the single
// output register set that figure: the input is stalled only while a held result is stalled
// downstream. Bytes of the 12-byte header, the type bytes and the first class byte give
// no result unless they carry end_of_packet; after done or an error bytes are dropped
// until end_of_packet, which always returns the parser to its reset state.
module dns_question_name_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dnsqn_pkg::DATA_W-1:0]  data_byte_i,
  input  logic                          end_of_packet_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dnsqn_pkg::KIND_W-1:0]  result_kind_o,
  output logic [dnsqn_pkg::DATA_W-1:0]  name_char_o,
  output logic [dnsqn_pkg::QTYPE_W-1:0] query_type_o,
  output logic [dnsqn_pkg::NLEN_W-1:0]  name_length_o,
  output logic [dnsqn_pkg::ERR_W-1:0]   error_code_o
);
  import dnsqn_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  localparam logic [TLEN_W-1:0] TLEN_LIMIT = TLEN_W'(NAME_BYTES - 1);

  logic [2:0]        phase_q, phase_d;
  logic [3:0]        hdr_cnt_q, hdr_cnt_d;
  logic [5:0]        lbl_rem_q, lbl_rem_d;
  logic [TLEN_W-1:0] tlen_q, tlen_d;
  logic              first_q, first_d;
  logic [1:0]        tail_cnt_q, tail_cnt_d;
  logic [7:0]        type_hi_q, type_hi_d;
  logic [7:0]        type_lo_q, type_lo_d;

  logic                out_valid_q;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [DATA_W-1:0]   char_q, char_d;
  logic [QTYPE_W-1:0]  qtype_q, qtype_d;
  logic [NLEN_W-1:0]   nlen_q, nlen_d;
  logic [ERR_W-1:0]    err_q, err_d;
  logic                emit;

  logic in_xfer;
  logic name_full;
  logic [DATA_W-1:0] b;
  logic last;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign name_full  = tlen_q >= TLEN_LIMIT;
  assign b          = data_byte_i;
  assign last       = end_of_packet_i;

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    lbl_rem_d  = lbl_rem_q;
    tlen_d     = tlen_q;
    first_d    = first_q;
    tail_cnt_d = tail_cnt_q;
    type_hi_d  = type_hi_q;
    type_lo_d  = type_lo_q;
    emit       = 1'b0;
    kind_d     = KIND_CHAR;
    char_d     = '0;
    qtype_d    = '0;
    nlen_d     = '0;
    err_d      = ERR_LABEL;

    case (phase_q)
      PH_HEADER: begin
        if (last) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_TRUNC; phase_d = PH_SKIP;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_cnt_d >= HEADER_BYTES) phase_d = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (b == '0) begin
          if (last) begin
            emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_TRUNC; phase_d = PH_SKIP;
          end else begin
            phase_d    = PH_TAIL;
            tail_cnt_d = '0;
          end
        end else if (b > MAX_LABEL) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_LABEL; phase_d = PH_SKIP;
        end else if (last) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_TRUNC; phase_d = PH_SKIP;
        end else if (first_q) begin
          first_d   = 1'b0;
          lbl_rem_d = b[5:0];
          phase_d   = PH_BODY;
        end else if (name_full) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_NAME; phase_d = PH_SKIP;
        end else begin
          tlen_d    = tlen_q + 1'b1;
          lbl_rem_d = b[5:0];
          phase_d   = PH_BODY;
          emit      = 1'b1;
          char_d    = DOT_CHAR;
        end
      end
      PH_BODY: begin
        if (last) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_TRUNC; phase_d = PH_SKIP;
        end else if (name_full) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_NAME; phase_d = PH_SKIP;
        end else begin
          tlen_d    = tlen_q + 1'b1;
          lbl_rem_d = lbl_rem_q - 6'd1;
          if (lbl_rem_d == '0) phase_d = PH_LENGTH;
          emit   = 1'b1;
          char_d = b;
        end
      end
      PH_TAIL: begin
        if (tail_cnt_q == 2'd0) type_hi_d = b;
        if (tail_cnt_q == 2'd1) type_lo_d = b;
        if (tail_cnt_q == TAIL_LAST) begin
          emit    = 1'b1;
          kind_d  = KIND_DONE;
          qtype_d = {type_hi_q, type_lo_q};
          nlen_d  = NLEN_W'(tlen_q);
          phase_d = PH_SKIP;
        end else if (last) begin
          emit = 1'b1; kind_d = KIND_ERROR; err_d = ERR_TRUNC; phase_d = PH_SKIP;
        end else begin
          tail_cnt_d = tail_cnt_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase

    if (last) begin
      phase_d    = PH_HEADER;
      hdr_cnt_d  = '0;
      lbl_rem_d  = '0;
      tlen_d     = '0;
      first_d    = 1'b1;
      tail_cnt_d = '0;
      type_hi_d  = '0;
      type_lo_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      lbl_rem_q  <= '0;
      tlen_q     <= '0;
      first_q    <= 1'b1;
      tail_cnt_q <= '0;
      type_hi_q  <= '0;
      type_lo_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q    <= phase_d;
        hdr_cnt_q  <= hdr_cnt_d;
        lbl_rem_q  <= lbl_rem_d;
        tlen_q     <= tlen_d;
        first_q    <= first_d;
        tail_cnt_q <= tail_cnt_d;
        type_hi_q  <= type_hi_d;
        type_lo_q  <= type_lo_d;
      end
      if (!in_stall_o) out_valid_q <= in_xfer & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      kind_q  <= kind_d;
      char_q  <= char_d;
      qtype_q <= qtype_d;
      nlen_q  <= nlen_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign name_char_o   = char_q;
  assign query_type_o  = qtype_q;
  assign name_length_o = nlen_q;
  assign error_code_o  = err_q;

  a_eop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && end_of_packet_i |=> phase_q == PH_HEADER && tlen_q == '0 && first_q)
    else $error("end of packet did not clear parser state");

  a_tlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tlen_q <= TLEN_W'(NAME_BYTES - 1))
    else $error("name length beyond limit");

  a_body_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> lbl_rem_q != '0)
    else $error("body phase with no label bytes left");

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_CHAR |->
      query_type_o == '0 && name_length_o == '0 && error_code_o == '0)
    else $error("character result carries stray fields");

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && phase_q == PH_SKIP && !in_stall_o |=> !out_valid_o)
    else $error("result produced while skipping");

endmodule
